>>> rtl/flv_pkg.sv
// Shared codes, character constants and word tables for the float literal checker.
package flv_pkg;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_VALID   = 2'd0;
	localparam status_t STATUS_EMPTY   = 2'd1;
	localparam status_t STATUS_INVALID = 2'd2;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_LOW_I  = 8'h69;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CASE_FOLD = 8'd32;

	localparam logic [3:0] INF_SHORT_LEN = 4'd3;
	localparam logic [3:0] INF_LONG_LEN  = 4'd8;
	localparam logic [3:0] NAN_LEN       = 4'd3;

	// Per-byte classification handed from the classifier to the parser.
	typedef struct packed {
		logic       digit;
		logic       sign;
		logic       dot;
		logic       exp_mark;
		logic [7:0] folded;
	} char_class_t;

	// Letter expected at a given position of "infinity".
	function automatic logic [7:0] inf_letter(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h69;
			3'd1:    c = 8'h6E;
			3'd2:    c = 8'h66;
			3'd3:    c = 8'h69;
			3'd4:    c = 8'h6E;
			3'd5:    c = 8'h69;
			3'd6:    c = 8'h74;
			3'd7:    c = 8'h79;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Letter expected at a given position of "nan".
	function automatic logic [7:0] nan_letter(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h6E;
			2'd1:    c = 8'h61;
			2'd2:    c = 8'h6E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/flv_classify.sv
// Byte classifier: digit, sign, dot and exponent marks, and the case-folded byte.
module flv_classify (
	input  logic                 [7:0] ch,
	output flv_pkg::char_class_t       cls
);

	always_comb begin
		cls.digit    = (ch >= flv_pkg::CH_ZERO) && (ch <= flv_pkg::CH_NINE);
		cls.sign     = (ch == flv_pkg::CH_PLUS) || (ch == flv_pkg::CH_MINUS);
		cls.dot      = (ch == flv_pkg::CH_DOT);
		cls.exp_mark = (ch == flv_pkg::CH_LOW_E) || (ch == flv_pkg::CH_UP_E);
		if ((ch >= flv_pkg::CH_UP_A) && (ch <= flv_pkg::CH_UP_Z)) begin
			cls.folded = ch + flv_pkg::CASE_FOLD;
		end else begin
			cls.folded = ch;
		end
	end

endmodule

>>> rtl/flv_parser.sv
// Grammar state machine: advances one byte per step and gives the status at the end marker.
module flv_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 is_end,
	input  flv_pkg::char_class_t cls,
	output flv_pkg::status_t     status
);

	typedef enum logic [3:0] {
		PH_START,
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_EXP,
		PH_EXP_SIGN,
		PH_EXP_DIG,
		PH_WORD,
		PH_BAD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_INF,
		KIND_NAN
	} word_kind_t;

	phase_t     phase_q, phase_d, lead_phase;
	word_kind_t kind_q, kind_d, lead_kind;
	logic [3:0] word_pos_q, word_pos_d;
	logic       mant_q, mant_d, lead_mant;
	logic       exp_q, exp_d;
	logic       any_q;
	logic       inf_match, nan_match;

	// First byte of a mantissa or a word, after the optional sign.
	always_comb begin
		lead_kind = KIND_NONE;
		lead_mant = mant_q;
		if (cls.digit) begin
			lead_phase = PH_INT;
			lead_mant  = 1'b1;
		end else if (cls.dot) begin
			lead_phase = PH_FRAC;
		end else if (cls.folded == flv_pkg::CH_LOW_I) begin
			lead_phase = PH_WORD;
			lead_kind  = KIND_INF;
		end else if (cls.folded == flv_pkg::CH_LOW_N) begin
			lead_phase = PH_WORD;
			lead_kind  = KIND_NAN;
		end else begin
			lead_phase = PH_BAD;
		end
	end

	assign inf_match = (kind_q == KIND_INF) && (word_pos_q < flv_pkg::INF_LONG_LEN)
		&& (cls.folded == flv_pkg::inf_letter(word_pos_q[2:0]));
	assign nan_match = (kind_q == KIND_NAN) && (word_pos_q < flv_pkg::NAN_LEN)
		&& (cls.folded == flv_pkg::nan_letter(word_pos_q[1:0]));

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		word_pos_d = word_pos_q;
		mant_d     = mant_q;
		exp_d      = exp_q;
		case (phase_q)
			PH_START, PH_SIGN: begin
				if ((phase_q == PH_START) && cls.sign) begin
					phase_d = PH_SIGN;
				end else begin
					phase_d = lead_phase;
					mant_d  = lead_mant;
					if (lead_kind != KIND_NONE) begin
						kind_d     = lead_kind;
						word_pos_d = 4'd1;
					end
				end
			end
			PH_INT: begin
				if (cls.digit) begin
					mant_d = 1'b1;
				end else if (cls.dot) begin
					phase_d = PH_FRAC;
				end else if (cls.exp_mark) begin
					phase_d = PH_EXP;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_FRAC: begin
				if (cls.digit) begin
					mant_d = 1'b1;
				end else if (cls.exp_mark && mant_q) begin
					phase_d = PH_EXP;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_EXP: begin
				if (cls.sign) begin
					phase_d = PH_EXP_SIGN;
				end else if (cls.digit) begin
					phase_d = PH_EXP_DIG;
					exp_d   = 1'b1;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_EXP_SIGN, PH_EXP_DIG: begin
				if (cls.digit) begin
					phase_d = PH_EXP_DIG;
					exp_d   = 1'b1;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_WORD: begin
				if (inf_match || nan_match) begin
					word_pos_d = word_pos_q + 4'd1;
				end else begin
					phase_d = PH_BAD;
				end
			end
			default: begin
				phase_d = PH_BAD;
			end
		endcase
	end

	always_comb begin
		if (!any_q) begin
			status = flv_pkg::STATUS_EMPTY;
		end else begin
			case (phase_q)
				PH_INT:     status = flv_pkg::STATUS_VALID;
				PH_FRAC:    status = mant_q ? flv_pkg::STATUS_VALID : flv_pkg::STATUS_INVALID;
				PH_EXP_DIG: status = exp_q ? flv_pkg::STATUS_VALID : flv_pkg::STATUS_INVALID;
				PH_WORD: begin
					if ((kind_q == KIND_INF) && ((word_pos_q == flv_pkg::INF_SHORT_LEN)
						|| (word_pos_q == flv_pkg::INF_LONG_LEN))) begin
						status = flv_pkg::STATUS_VALID;
					end else if ((kind_q == KIND_NAN) && (word_pos_q == flv_pkg::NAN_LEN)) begin
						status = flv_pkg::STATUS_VALID;
					end else begin
						status = flv_pkg::STATUS_INVALID;
					end
				end
				default:    status = flv_pkg::STATUS_INVALID;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			kind_q     <= KIND_NONE;
			word_pos_q <= 4'd0;
			mant_q     <= 1'b0;
			exp_q      <= 1'b0;
			any_q      <= 1'b0;
		end else if (step) begin
			if (is_end) begin
				phase_q    <= PH_START;
				kind_q     <= KIND_NONE;
				word_pos_q <= 4'd0;
				mant_q     <= 1'b0;
				exp_q      <= 1'b0;
				any_q      <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				kind_q     <= kind_d;
				word_pos_q <= word_pos_d;
				mant_q     <= mant_d;
				exp_q      <= exp_d;
				any_q      <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/float_literal_validator_core.sv
// Top level of the float literal checker: input register, parser and result register.
// A status reaches the master side once the end-marker item has passed the input
// register and then the result register.
// Throughput: one item per cycle, except while an end marker holds the slave side.
// The input register keeps filling while a status waits; only an end marker that meets a
// full, stalled result register holds the slave side.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to the
// start of a string.
module float_literal_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] ch
	input  logic       s_tuser,  // [0] is_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [1:0] status, [7:2] zero
);

	// Input register holding one accepted item.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       is_end_s1;

	// Result register holding one status.
	logic             valid_s2;
	flv_pkg::status_t status_s2;

	flv_pkg::char_class_t cls;
	flv_pkg::status_t     status;
	logic                 advance;

	// An item in the input register moves on unless it is an end marker and the result
	// register is occupied and not being drained.
	assign advance  = valid_s1 && (!is_end_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1     <= s_tdata;
			is_end_s1 <= s_tuser;
		end
	end

	flv_classify u_classify (
		.ch  (ch_s1),
		.cls (cls)
	);

	flv_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.is_end (is_end_s1),
		.cls    (cls),
		.status (status)
	);

	// The status is captured as the end marker leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && is_end_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end_s1) begin
			status_s2 <= status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, status_s2};

`ifndef SYNTHESIS
	// A new status appears only after an end marker left the input register.
	a_status_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance && is_end_s1))
		else $error("status raised without an end marker");

	// The unused status code is never produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((status_s2 == flv_pkg::STATUS_VALID)
			|| (status_s2 == flv_pkg::STATUS_EMPTY)
			|| (status_s2 == flv_pkg::STATUS_INVALID)))
		else $error("undefined status code");

	// An end marker facing a stalled, full result register must hold the slave side.
	a_end_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_end_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("end marker would overwrite a pending status");

	// A byte item never blocks the slave side.
	a_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !is_end_s1) |-> s_tready)
		else $error("byte item stalled the input");
`endif

endmodule

>>> tb/sv/tb_float_literal_validator_core.sv
// Testbench for float_literal_validator_core: stream stimulus, status prediction and checking.
`timescale 1ns / 1ps

module tb_float_literal_validator_core;

	// Parser position used by the predictor. The numbering is private to this file.
	typedef enum logic [3:0] {
		AT_START, AFTER_SIGN, IN_INT, IN_FRAC, AFTER_E, AFTER_EXP_SIGN, IN_EXP, IN_WORD,
		REJECTED
	} parse_phase_t;

	typedef enum logic [1:0] {NO_WORD, WORD_INF, WORD_NAN} word_kind_t;

	// One item on the slave side: a string byte, or an end marker whose byte is ignored.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} stream_item_t;

	// Tracks the grammar for the bytes that were accepted so far and keeps the statuses
	// that the end markers will produce, oldest first.
	class literal_checker;
		parse_phase_t     phase;
		word_kind_t       word;
		logic [3:0]       letters_matched;
		bit               mant_digit;
		bit               exp_digit;
		bit               got_byte;
		flv_pkg::status_t pending_status[$];
		int               failures;
		string            inf_word = "infinity";
		string            nan_word = "nan";

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			phase = AT_START;
			word = NO_WORD;
			letters_matched = 4'd0;
			mant_digit = 1'b0;
			exp_digit = 1'b0;
			got_byte = 1'b0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= flv_pkg::CH_ZERO && c <= flv_pkg::CH_NINE;
		endfunction

		function bit is_sign(logic [7:0] c);
			return c == flv_pkg::CH_PLUS || c == flv_pkg::CH_MINUS;
		endfunction

		function bit is_exp_mark(logic [7:0] c);
			return c == flv_pkg::CH_LOW_E || c == flv_pkg::CH_UP_E;
		endfunction

		// Only A to Z are folded; every other byte passes unchanged.
		function logic [7:0] lower(logic [7:0] c);
			if (c >= flv_pkg::CH_UP_A && c <= flv_pkg::CH_UP_Z) begin
				return c + flv_pkg::CASE_FOLD;
			end
			return c;
		endfunction

		// First byte of the body, after an optional sign: a mantissa or one of the words.
		function void open_body(logic [7:0] c);
			if (is_digit(c)) begin
				mant_digit = 1'b1;
				phase = IN_INT;
			end else if (c == flv_pkg::CH_DOT) begin
				phase = IN_FRAC;
			end else if (lower(c) == flv_pkg::CH_LOW_I) begin
				word = WORD_INF;
				letters_matched = 4'd1;
				phase = IN_WORD;
			end else if (lower(c) == flv_pkg::CH_LOW_N) begin
				word = WORD_NAN;
				letters_matched = 4'd1;
				phase = IN_WORD;
			end else begin
				phase = REJECTED;
			end
		endfunction

		// Any byte past the end of the word, or a wrong letter, rejects the string.
		function void extend_word(logic [7:0] c);
			if (word == WORD_INF && letters_matched < flv_pkg::INF_LONG_LEN
					&& lower(c) == inf_word[letters_matched]) begin
				letters_matched++;
			end else if (word == WORD_NAN && letters_matched < flv_pkg::NAN_LEN
					&& lower(c) == nan_word[letters_matched]) begin
				letters_matched++;
			end else begin
				phase = REJECTED;
			end
		endfunction

		function flv_pkg::status_t closing_status();
			if (!got_byte) begin
				return flv_pkg::STATUS_EMPTY;
			end
			case (phase)
				IN_INT:  return flv_pkg::STATUS_VALID;
				IN_FRAC: return mant_digit ? flv_pkg::STATUS_VALID : flv_pkg::STATUS_INVALID;
				IN_EXP:  return exp_digit ? flv_pkg::STATUS_VALID : flv_pkg::STATUS_INVALID;
				IN_WORD: begin
					if (word == WORD_INF && (letters_matched == flv_pkg::INF_SHORT_LEN
							|| letters_matched == flv_pkg::INF_LONG_LEN)) begin
						return flv_pkg::STATUS_VALID;
					end
					if (word == WORD_NAN && letters_matched == flv_pkg::NAN_LEN) begin
						return flv_pkg::STATUS_VALID;
					end
					return flv_pkg::STATUS_INVALID;
				end
				default: return flv_pkg::STATUS_INVALID;
			endcase
		endfunction

		// Called for every item accepted on the slave side.
		function void take_item(stream_item_t it);
			if (it.is_end) begin
				pending_status.push_back(closing_status());
				restart();
				return;
			end
			got_byte = 1'b1;
			case (phase)
				AT_START: begin
					if (is_sign(it.ch)) begin
						phase = AFTER_SIGN;
					end else begin
						open_body(it.ch);
					end
				end
				AFTER_SIGN: open_body(it.ch);
				IN_INT: begin
					if (is_digit(it.ch)) begin
						mant_digit = 1'b1;
					end else if (it.ch == flv_pkg::CH_DOT) begin
						phase = IN_FRAC;
					end else if (is_exp_mark(it.ch)) begin
						phase = AFTER_E;
					end else begin
						phase = REJECTED;
					end
				end
				IN_FRAC: begin
					if (is_digit(it.ch)) begin
						mant_digit = 1'b1;
					end else if (is_exp_mark(it.ch) && mant_digit) begin
						phase = AFTER_E;
					end else begin
						phase = REJECTED;
					end
				end
				AFTER_E: begin
					if (is_sign(it.ch)) begin
						phase = AFTER_EXP_SIGN;
					end else if (is_digit(it.ch)) begin
						exp_digit = 1'b1;
						phase = IN_EXP;
					end else begin
						phase = REJECTED;
					end
				end
				AFTER_EXP_SIGN, IN_EXP: begin
					if (is_digit(it.ch)) begin
						exp_digit = 1'b1;
						phase = IN_EXP;
					end else begin
						phase = REJECTED;
					end
				end
				IN_WORD: extend_word(it.ch);
				default: phase = REJECTED;
			endcase
		endfunction

		// Called for every status taken from the master side.
		function void check_status(logic [7:0] data);
			flv_pkg::status_t want;
			if (pending_status.size() == 0) begin
				$error("status: no result expected, got %0d", data[1:0]);
				failures++;
				return;
			end
			want = pending_status.pop_front();
			if (data[1:0] !== want) begin
				$error("status: expected %0d, got %0d", want, data[1:0]);
				failures++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	float_literal_validator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	literal_checker sb;
	stream_item_t   stim_items[$];
	int             sent_count = 0;

	task automatic add_byte(logic [7:0] c);
		stream_item_t it;
		it.ch = c;
		it.is_end = 1'b0;
		stim_items.push_back(it);
	endtask

	// The end marker carries a random byte, which the block has to ignore.
	task automatic close_string();
		stream_item_t it;
		it.ch = 8'($urandom_range(0, 255));
		it.is_end = 1'b1;
		stim_items.push_back(it);
	endtask

	task automatic add_string(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
		close_string();
	endtask

	// Mostly well-formed literals with random content; some are cut short, run long,
	// get a stray byte, or are plain noise, so every rejection path gets traffic.
	task automatic add_random_string();
		logic [7:0] text[$];
		logic [7:0] c;
		string      w;
		int         pick;
		int         n;
		int         pos;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			close_string();
			return;
		end
		if (pick < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
			close_string();
			return;
		end
		if ($urandom_range(0, 9) < 4) begin
			text.push_back($urandom_range(0, 1) ? flv_pkg::CH_PLUS : flv_pkg::CH_MINUS);
		end
		if (pick < 32) begin
			case ($urandom_range(0, 2))
				0: w = "inf";
				1: w = "infinity";
				default: w = "nan";
			endcase
			n = w.len();
			// A partial word or one with an extra letter is mostly rejected, though the result can still spell a valid word.
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, w.len() - 1);
			end
			for (int i = 0; i < n; i++) begin
				c = w[i];
				if ($urandom_range(0, 1)) begin
					c = c - flv_pkg::CASE_FOLD;
				end
				text.push_back(c);
			end
			if ($urandom_range(0, 5) == 0) begin
				text.push_back("a" + 8'($urandom_range(0, 25)));
			end
		end else begin
			repeat ($urandom_range(0, 4))
				text.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 1)) begin
				text.push_back(flv_pkg::CH_DOT);
				repeat ($urandom_range(0, 4))
					text.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 9) < 4) begin
				text.push_back($urandom_range(0, 1) ? flv_pkg::CH_LOW_E : flv_pkg::CH_UP_E);
				if ($urandom_range(0, 1)) begin
					text.push_back($urandom_range(0, 1) ? flv_pkg::CH_PLUS : flv_pkg::CH_MINUS);
				end
				repeat ($urandom_range(0, 3))
					text.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 99) < 15) begin
			c = 8'($urandom_range(0, 255));
			pos = $urandom_range(0, text.size());
			if (pos < text.size() && $urandom_range(0, 1)) begin
				text[pos] = c;
			end else begin
				text.insert(pos, c);
			end
		end
		foreach (text[i]) begin
			add_byte(text[i]);
		end
		close_string();
	endtask

	// Sender: bursts of random length separated by random gaps. Valid stays up until the
	// item is taken; a gap only opens after an accepted item.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.take_item(stim_items[sent_count]);
				sent_count++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sent_count < stim_items.size()) begin
					s_tvalid <= 1'b1;
					s_tdata <= stim_items[sent_count].ch;
					s_tuser <= stim_items[sent_count].is_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (!s_tvalid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sent_count < stim_items.size()) begin
					s_tvalid <= 1'b1;
					s_tdata <= stim_items[sent_count].ch;
					s_tuser <= stim_items[sent_count].is_end;
				end
			end
		end
	end

	// Receiver: stalls by a rotating pattern that is redrawn now and then, sometimes all
	// ready. Once, after a few dozen statuses, it holds off for a long stretch so that
	// the result register stays full and the block has to stall its slave side.
	logic [15:0] stall_pattern = 16'hFFFF;
	int          pattern_age = 0;
	int          results_taken = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_status(m_tdata);
				results_taken++;
			end
			if (!hold_done && results_taken >= 30) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
				pattern_age++;
				if (pattern_age == 64) begin
					pattern_age = 0;
					stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
						: 16'($urandom_range(0, 65535)) | 16'h0001;
				end
			end
		end
	end

	initial begin
		sb = new();

		// Directed strings: the plain and signed mantissa with exponent, a lone dot and a
		// lone sign, inf and infinity in mixed case and nan in lower case, a partial word, an
		// exponent with no digit, and the byte extremes zero and 0xFF, which are both rejected.
		add_string("");
		add_string("7");
		add_string("+.5E-3");
		add_string(".");
		add_string("-");
		add_string("iNf");
		add_string("InFiNiTy");
		add_string("nan");
		add_string("infi");
		add_string("1e");
		add_byte(8'h00);
		close_string();
		add_byte(8'hFF);
		close_string();

		while (stim_items.size() < 1800) begin
			add_random_string();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count < stim_items.size()) begin
			@(posedge clk);
		end
		while (sb.pending_status.size() != 0) begin
			@(posedge clk);
		end
		// The wait below catches any stray status.
		repeat (8) @(posedge clk);

		if (sb.failures == 0) begin
			$display("** float_literal_validator_core: PASSED **");
		end else begin
			$display("** float_literal_validator_core: FAILED **");
		end
		$finish;
	end

	// Far beyond the slowest legal run, long receiver hold-off included.
	initial begin
		#2_000_000;
		$display("** float_literal_validator_core: FAILED **");
		$finish;
	end

endmodule
